FILE: rtl/sgsb_pkg.sv
// ----------------------------------------------------------------------------
// sgsb_pkg
// Shared types for the scaled glyph span blitter: beat payloads and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sgsb_pkg;

	typedef struct packed {
		logic [8:0]  x_origin;
		logic [8:0]  y_origin;
		logic [15:0] pixel_color;
		logic [3:0]  scale;
		logic [3:0]  row_index;
		logic [7:0]  row_bits;
	} glyph_row_t;

	typedef struct packed {
		logic [17:0] span_address;
		logic [3:0]  span_length;
		logic [15:0] span_color;
		logic        out_of_frame;
		logic        last_span;
	} span_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic emit;
	} sgsb_cmd_t;

	typedef struct packed {
		logic empty;
		logic item_end;
	} sgsb_status_t;

endpackage

FILE: rtl/sgsb_ctrl.sv
// ----------------------------------------------------------------------------
// sgsb_ctrl
// Controller: accepts a row, waits in setup for the line base (empty rows end
// there), then sequences one span per cycle until the datapath flags the last.
// ----------------------------------------------------------------------------
module sgsb_ctrl
	import sgsb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	output logic         strobe,
	output sgsb_cmd_t    cmd,
	input  sgsb_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   strobe_q;

	always_comb begin
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.setup = (state_q == ST_SETUP);
		cmd.emit  = (state_q == ST_EMIT);
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					if (status.empty)
						state_q <= ST_IDLE;
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (status.item_end)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/sgsb_datapath.sv
// ----------------------------------------------------------------------------
// sgsb_datapath
// Datapath: holds the row, the current line and its framebuffer base,
// picks the leftmost pending pixel each cycle and forms the span beat.
// ----------------------------------------------------------------------------
module sgsb_datapath
	import sgsb_pkg::*;
#(
	parameter int unsigned LINE_PIXELS   = 480,
	parameter int unsigned FRAME_LINES   = 320,
	parameter int unsigned GLYPH_COLUMNS = 8,
	parameter int unsigned GLYPH_ROWS    = 16,
	parameter int unsigned MAX_SCALE     = 8
) (
	input  logic         clk,
	input  glyph_row_t   item,
	input  sgsb_cmd_t    cmd,
	output sgsb_status_t status,
	output span_t        span
);

	localparam int unsigned COLS     = (GLYPH_COLUMNS > 8) ? 8 : GLYPH_COLUMNS;
	localparam logic [7:0]  COL_MASK = ~(8'hFF >> COLS);
	localparam logic [12:0] LP_W     = 13'(LINE_PIXELS);
	localparam logic [12:0] FL_W     = 13'(FRAME_LINES);
	localparam logic [5:0]  GR_W     = 6'(GLYPH_ROWS);
	localparam logic [3:0]  MS_W     = 4'(MAX_SCALE);

	logic [8:0]  x0_q;
	logic [15:0] color_q;
	logic [3:0]  s_q;
	logic [7:0]  bits_q;
	logic [7:0]  rem_q;
	logic [9:0]  line_q;
	logic [3:0]  k_q;
	logic [17:0] base_q;
	logic        empty_q;
	span_t       span_q;

	logic [3:0]  s_cl;
	logic [7:0]  bits_m;
	logic [7:0]  row_sc;
	logic [22:0] base_prod;
	logic [2:0]  pos;
	logic [2:0]  col;
	logic [6:0]  col_off;
	logic [9:0]  xs;
	logic [7:0]  rem_nx;
	logic        line_end;
	logic        last_line;
	logic        oof;

	always_comb begin
		s_cl   = (item.scale > MS_W) ? MS_W : item.scale;
		bits_m = item.row_bits & COL_MASK;
		row_sc = 8'(item.row_index) * 8'(s_cl);
	end

	assign base_prod = 23'(line_q) * 23'(LP_W);

	always_comb begin
		pos = 3'd0;
		for (int i = 0; i < 8; i++)
			if (rem_q[i])
				pos = 3'(i);
	end

	always_comb begin
		col       = ~pos;
		col_off   = 7'(col) * 7'(s_q + 4'd1);
		xs        = 10'(x0_q) + 10'(col_off);
		rem_nx    = rem_q & ~(8'h01 << pos);
		line_end  = (rem_nx == 8'h00);
		last_line = (k_q == s_q - 4'd1);
		oof       = ((13'(xs) + 13'(s_q)) >= LP_W) || (13'(line_q) >= FL_W);
	end

	assign status.empty    = empty_q;
	assign status.item_end = line_end && last_line;
	assign span            = span_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q    <= item.x_origin;
			color_q <= item.pixel_color;
			s_q     <= s_cl;
			bits_q  <= bits_m;
			rem_q   <= bits_m;
			line_q  <= 10'(item.y_origin) + 10'(row_sc);
			k_q     <= 4'd0;
			empty_q <= (s_cl == 4'd0) || (bits_m == 8'h00) ||
			           ({2'b00, item.row_index} >= GR_W);
		end
		if (cmd.setup)
			base_q <= base_prod[17:0];
		if (cmd.emit) begin
			span_q.span_address <= base_q + 18'(xs);
			span_q.span_length  <= s_q + 4'd1;
			span_q.span_color   <= color_q;
			span_q.out_of_frame <= oof;
			span_q.last_span    <= line_end && last_line;
			if (line_end) begin
				rem_q  <= bits_q;
				k_q    <= k_q + 4'd1;
				line_q <= line_q + 10'd1;
				base_q <= base_q + 18'(LINE_PIXELS);
			end else begin
				rem_q <= rem_nx;
			end
		end
	end

endmodule

FILE: rtl/scaled_glyph_span_blitter.sv
// ----------------------------------------------------------------------------
// scaled_glyph_span_blitter
// Turns one 8-pixel glyph row into scaled framebuffer write spans.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------
//  row in   | start / busy    | item (glyph_row_t)
//  span out | strobe (1 beat) | span (span_t)
//
//  An item is captured, then its line base address is formed, then the
//  emit sequencer forms one span beat per cycle. An item with no spans
//  returns to idle from the setup state.
//  busy is high from the cycle after start until the last beat is formed.
//  Reset clears the controller only. Beats are shown for one cycle each.
// ----------------------------------------------------------------------------
module scaled_glyph_span_blitter
	import sgsb_pkg::*;
#(
	parameter int unsigned LINE_PIXELS   = 480,
	parameter int unsigned FRAME_LINES   = 320,
	parameter int unsigned GLYPH_COLUMNS = 8,
	parameter int unsigned GLYPH_ROWS    = 16,
	parameter int unsigned MAX_SCALE     = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  glyph_row_t item,
	output logic       strobe,
	output span_t      span
);

	sgsb_cmd_t    cmd;
	sgsb_status_t status;

	sgsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.strobe (strobe),
		.cmd    (cmd),
		.status (status)
	);

	sgsb_datapath #(
		.LINE_PIXELS   (LINE_PIXELS),
		.FRAME_LINES   (FRAME_LINES),
		.GLYPH_COLUMNS (GLYPH_COLUMNS),
		.GLYPH_ROWS    (GLYPH_ROWS),
		.MAX_SCALE     (MAX_SCALE)
	) u_datapath (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.span   (span)
	);

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the scaled glyph span blitter against an in-bench span predictor.
// Glyph rows are queued up front and driven on start/busy. Every span beat
// is compared field by field with the oldest predicted span. The run opens
// with edge and special cases (zero scale, empty row, clamped scale, frame
// edges, address wrap), then continues with random rows.
// ----------------------------------------------------------------------------
module testbench;
	import sgsb_pkg::*;

	localparam int unsigned LINE_PIXELS    = 480;
	localparam int unsigned FRAME_LINES    = 320;
	localparam int unsigned GLYPH_COLUMNS  = 8;
	localparam int unsigned GLYPH_ROWS     = 16;
	localparam int unsigned MAX_SCALE      = 8;
	localparam int          RANDOM_ROWS    = 445;
	localparam int          QUIET_TAIL     = 40;
	localparam int          DRAIN_EVERY    = 150;
	localparam int          SETTLE_CYCLES  = 80;
	localparam int          WATCHDOG_LIMIT = 4000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	glyph_row_t item;
	logic       strobe;
	span_t      span;

	glyph_row_t pending_rows[$];
	span_t      span_due[$];
	logic       row_taken = 1'b0;
	int         gap_cycles = 0;
	int         rows_sent = 0;
	bit         drain_wait = 1'b0;
	int         mismatches = 0;
	int         quiet_cycles = 0;

	scaled_glyph_span_blitter #(
		.LINE_PIXELS  (LINE_PIXELS),
		.FRAME_LINES  (FRAME_LINES),
		.GLYPH_COLUMNS(GLYPH_COLUMNS),
		.GLYPH_ROWS   (GLYPH_ROWS),
		.MAX_SCALE    (MAX_SCALE)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.strobe(strobe),
		.span  (span)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// all spans of one glyph row, line by line, leftmost column first
	function automatic void predict_spans(input glyph_row_t r);
		int unsigned s;
		int unsigned cols;
		int unsigned line;
		int unsigned xs;
		int          total;
		int          emitted;
		span_t       sp;
		s = (r.scale > MAX_SCALE) ? MAX_SCALE : r.scale;
		cols = (GLYPH_COLUMNS > 8) ? 8 : GLYPH_COLUMNS;
		if (s == 0 || r.row_bits == 0 || r.row_index >= GLYPH_ROWS)
			return;
		total = 0;
		for (int c = 0; c < cols; c++)
			if (r.row_bits[7 - c])
				total += s;
		emitted = 0;
		for (int k = 0; k < s; k++) begin
			line = r.y_origin + r.row_index * s + k;
			for (int c = 0; c < cols; c++) begin
				if (r.row_bits[7 - c]) begin
					xs = r.x_origin + c * (s + 1);
					emitted++;
					sp.span_address = 18'(line * LINE_PIXELS + xs);
					sp.span_length  = 4'(s + 1);
					sp.span_color   = r.pixel_color;
					sp.out_of_frame = (xs + s >= LINE_PIXELS) || (line >= FRAME_LINES);
					sp.last_span    = (emitted == total);
					span_due.push_back(sp);
				end
			end
		end
	endfunction

	task automatic queue_row(input int x, input int y, input int color, input int s,
			input int r, input int bits);
		glyph_row_t g;
		g.x_origin    = 9'(x);
		g.y_origin    = 9'(y);
		g.pixel_color = 16'(color);
		g.scale       = 4'(s);
		g.row_index   = 4'(r);
		g.row_bits    = 8'(bits);
		pending_rows.push_back(g);
	endtask

	function automatic glyph_row_t random_row();
		glyph_row_t g;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		g.pixel_color = 16'($urandom);
		g.row_index   = 4'($urandom_range(0, 15));
		if (pick < 70) begin
			g.x_origin = 9'($urandom_range(0, 479));
			g.y_origin = 9'($urandom_range(0, 319));
			g.scale    = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(5, 8)
				: $urandom_range(1, 4));
			g.row_bits = 8'($urandom_range(1, 255));
		end else if (pick < 85) begin
			g.x_origin = 9'($urandom_range(440, 511));
			g.y_origin = 9'($urandom_range(280, 511));
			g.scale    = 4'($urandom_range(1, 15));
			g.row_bits = 8'($urandom_range(1, 255));
		end else begin
			g.x_origin = 9'($urandom);
			g.y_origin = 9'($urandom);
			g.scale    = 4'($urandom);
			g.row_bits = 8'($urandom);
		end
		return g;
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (row_taken) begin
				void'(pending_rows.pop_front());
				rows_sent++;
				if (rows_sent % DRAIN_EVERY == 0 && pending_rows.size() > QUIET_TAIL)
					drain_wait = 1'b1;
				if (pending_rows.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
					gap_cycles = $urandom_range(1, 9);
			end
			if (start && !row_taken) begin
				// beat still offered, hold it
			end else if (gap_cycles != 0) begin
				gap_cycles--;
				start <= 1'b0;
			end else if (drain_wait) begin
				if (span_due.size() == 0 && !busy)
					drain_wait = 1'b0;
				start <= 1'b0;
			end else if (pending_rows.size() != 0) begin
				start <= 1'b1;
				item  <= pending_rows[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin : watch_spans
		span_t want;
		if (arst_n) begin
			if (strobe) begin
				if (span_due.size() == 0) begin
					report_mismatch($sformatf("unexpected span beat addr=%h", span.span_address));
				end else begin
					want = span_due.pop_front();
					if (span.span_address !== want.span_address)
						report_mismatch($sformatf("span_address %h, want %h",
							span.span_address, want.span_address));
					if (span.span_length !== want.span_length)
						report_mismatch($sformatf("span_length %0d, want %0d",
							span.span_length, want.span_length));
					if (span.span_color !== want.span_color)
						report_mismatch($sformatf("span_color %h, want %h",
							span.span_color, want.span_color));
					if (span.out_of_frame !== want.out_of_frame)
						report_mismatch($sformatf("out_of_frame %b, want %b at addr %h",
							span.out_of_frame, want.out_of_frame, want.span_address));
					if (span.last_span !== want.last_span)
						report_mismatch($sformatf("last_span %b, want %b at addr %h",
							span.last_span, want.last_span, want.span_address));
				end
			end
			if (start && !busy)
				predict_spans(item);
			row_taken <= start && !busy;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		glyph_row_t g;
		int         spanning;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;

		queue_row(0, 0, 16'h0000, 1, 0, 8'h80);
		queue_row(479, 319, 16'hFFFF, 8, 15, 8'hFF);
		queue_row(511, 511, 16'hFFFF, 15, 15, 8'hFF);
		queue_row(100, 100, 16'h1234, 0, 4, 8'hFF);
		queue_row(100, 100, 16'h1234, 3, 4, 8'h00);
		queue_row(478, 319, 16'h0F0F, 1, 0, 8'h80);
		queue_row(479, 319, 16'hF0F0, 1, 0, 8'h80);
		queue_row(0, 320, 16'h00FF, 1, 0, 8'h80);
		queue_row(100, 100, 16'hAAAA, 2, 7, 8'h01);
		queue_row(200, 50, 16'h5555, 3, 8, 8'h55);
		queue_row(10, 10, 16'hFF00, 9, 1, 8'hAA);
		queue_row(0, 0, 16'h7FFF, 1, 15, 8'hFF);
		queue_row(256, 256, 16'h8000, 4, 3, 8'h81);
		queue_row(471, 0, 16'h0001, 1, 0, 8'h01);
		queue_row(0, 0, 16'h0001, 8, 0, 8'h7E);
		queue_row(300, 200, 16'hC3C3, 12, 2, 8'h18);

		spanning = 0;
		while (spanning < RANDOM_ROWS) begin
			g = random_row();
			pending_rows.push_back(g);
			if (g.scale != 0 && g.row_bits != 0)
				spanning++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_rows.size() != 0 || start || busy || span_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0 && span_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/sgsb_pkg.sv
rtl/sgsb_ctrl.sv
rtl/sgsb_datapath.sv
rtl/scaled_glyph_span_blitter.sv
sim/testbench.sv
